// ===== sv/sflm_pkg.sv =====
// Package for the substring first/last match block.
// Holds sizes, register indexes and the payload and configuration types.
// No dependencies.
`timescale 1ns / 1ps
package sflm_pkg;

  localparam int LINE_MAX    = 1024;
  localparam int PATTERN_MAX = 16;

  localparam int BYTE_W    = 8;
  localparam int WORD_W    = 64;
  localparam int PAT_LEN_W = 5;
  localparam int IDX_W     = 10;
  localparam int POS_W     = $clog2(LINE_MAX + 1);
  localparam int SUM_W     = (POS_W > IDX_W) ? POS_W : IDX_W;
  localparam int PM_IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] line_byte;
    logic              end_of_line;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] first_start;
    logic [IDX_W-1:0] last_start;
  } out_item_t;

  typedef struct packed {
    logic [PATTERN_MAX-1:0][BYTE_W-1:0] pat;
    logic [PAT_LEN_W-1:0]               len;
  } pat_cfg_t;

endpackage

// ===== sv/substring_first_last_match.sv =====
// Substring first/last match block: streams the bytes of a line, one byte a transfer.
// A configured pattern of up to 16 bytes is searched with a shift-and vector.
// At the byte marked end_of_line one result gives found and the start indexes
// of the leftmost and rightmost full occurrence; the line state then clears.
// The user must write the pattern via the cfg_ port (index 0: bytes 0 to 7, index 1:
// bytes 8 to 15, index 2: length) while no line is in progress; not enforced here.
// Input and result channels use valid and stall; a transfer happens at a
// clock edge where valid is high and stall is low.
// A result passes the input register and then the result register.
// Throughput: one byte per cycle while in_stall is low, set by the single
// compare-and-shift step between the input register and the match state.
// When the receiver stalls, the result register holds its result; bytes that
// do not end a line keep flowing, and only a second end-of-line byte waits,
// which raises in_stall.
// Reset (rst_n low at a clock edge) clears the pattern, the line state and
// both channel registers.
// Depends on sflm_pkg, sflm_cfg and sflm_match.
`timescale 1ns / 1ps
module substring_first_last_match import sflm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  pat_cfg_t  pat_cfg;
  out_item_t result;
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      advance;
  logic      step;
  logic      out_valid_r;
  out_item_t out_item_r;

  sflm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pat_cfg   (pat_cfg)
  );

  sflm_match u_match (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .item    (s1_item_r),
    .pat_cfg (pat_cfg),
    .result  (result)
  );

  assign advance  = !s1_item_r.end_of_line || !out_valid_r || !out_stall;
  assign step     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && s1_item_r.end_of_line) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && s1_item_r.end_of_line) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_item_r.end_of_line && out_valid_r && out_stall))
    else $error("in_stall raised without a blocked end-of-line byte");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |->
      (out_data.first_start == '0 && out_data.last_start == '0))
    else $error("start indexes not zero on a result without a match");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_valid && !in_stall))
    else $error("channel registers not cleared after reset");

endmodule

// ===== sv/sflm_cfg.sv =====
// Configuration registers of the substring match block.
// Stores the pattern words and length and presents the clamped pattern.
// Depends on sflm_pkg.
`timescale 1ns / 1ps
module sflm_cfg import sflm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  output pat_cfg_t             pat_cfg
);

  logic [WORD_W-1:0]    pat_low_r;
  logic [WORD_W-1:0]    pat_high_r;
  logic [PAT_LEN_W-1:0] pat_len_r;
  logic [2*WORD_W-1:0]  pat_all;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PAT_LOW:  pat_low_r  <= cfg_data;
        REG_PAT_HIGH: pat_high_r <= cfg_data;
        REG_PAT_LEN:  pat_len_r  <= cfg_data[PAT_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign pat_all     = {pat_high_r, pat_low_r};
  assign pat_cfg.pat = pat_all[PATTERN_MAX*BYTE_W-1:0];
  assign pat_cfg.len = (pat_len_r > PAT_LEN_W'(PATTERN_MAX)) ?
                       PAT_LEN_W'(PATTERN_MAX) : pat_len_r;

endmodule

// ===== sv/sflm_match.sv =====
// Shift-and match engine of the substring match block.
// Tracks the partial match vector, line position and first and last starts.
// Depends on sflm_pkg.
`timescale 1ns / 1ps
module sflm_match import sflm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  input  pat_cfg_t  pat_cfg,
  output out_item_t result
);

  logic [PATTERN_MAX-1:0] vec_r, vec_nxt, vec_calc;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic                   seen_r, seen_nxt, seen_calc;
  logic [IDX_W-1:0]       left_r, left_nxt, left_calc;
  logic [IDX_W-1:0]       right_r, right_nxt, right_calc;
  logic [PATTERN_MAX-1:0] eq;
  logic [PATTERN_MAX-1:0] lmask;
  logic [PM_IDX_W-1:0]    top_idx;
  logic [SUM_W-1:0]       start;
  logic                   in_range;
  logic                   hit;

  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      eq[k]    = (pat_cfg.pat[k] == item.line_byte);
      lmask[k] = (PAT_LEN_W'(k) < pat_cfg.len);
    end
  end

  assign in_range = (pos_r < POS_W'(LINE_MAX));
  assign top_idx  = PM_IDX_W'(pat_cfg.len - PAT_LEN_W'(1));
  assign start    = SUM_W'(pos_r) - SUM_W'(pat_cfg.len - PAT_LEN_W'(1));

  always_comb begin
    vec_calc   = vec_r;
    seen_calc  = seen_r;
    left_calc  = left_r;
    right_calc = right_r;
    pos_nxt    = pos_r;
    hit        = 1'b0;
    if (in_range) begin
      vec_calc = {vec_r[PATTERN_MAX-2:0], 1'b1} & eq & lmask;
      hit      = (pat_cfg.len != '0) && vec_calc[top_idx];
      if (hit) begin
        if (!seen_r) begin
          left_calc = start[IDX_W-1:0];
        end
        right_calc = start[IDX_W-1:0];
        seen_calc  = 1'b1;
      end
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  always_comb begin
    result.found       = seen_calc;
    result.first_start = seen_calc ? left_calc : '0;
    result.last_start  = seen_calc ? right_calc : '0;
    if (item.end_of_line) begin
      vec_nxt   = '0;
      seen_nxt  = 1'b0;
      left_nxt  = '0;
      right_nxt = '0;
    end else begin
      vec_nxt   = vec_calc;
      seen_nxt  = seen_calc;
      left_nxt  = left_calc;
      right_nxt = right_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec_r   <= '0;
      pos_r   <= '0;
      seen_r  <= 1'b0;
      left_r  <= '0;
      right_r <= '0;
    end else if (step) begin
      vec_r   <= vec_nxt;
      pos_r   <= item.end_of_line ? '0 : pos_nxt;
      seen_r  <= seen_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

endmodule
